[rtl/ascii_number_parser_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII number parser
// Shared helpers that wrap concurrent assertions with clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASCII_NUMBER_PARSER_MACROS_SVH
`define ASCII_NUMBER_PARSER_MACROS_SVH

// Overlapping implication, checked out of reset.
`define ANP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ANP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/anp_pkg.sv]
// ----------------------------------------------------------------------------
// anp_pkg
// Types and constants shared by the ASCII number parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package anp_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned VALUE_W = 64;

	localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30; // '0'
	localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39; // '9'
	localparam logic [CHAR_W-1:0] CHAR_UP_A    = 8'h41; // 'A'
	localparam logic [CHAR_W-1:0] CHAR_UP_F    = 8'h46; // 'F'
	localparam logic [CHAR_W-1:0] CHAR_UP_X    = 8'h58; // 'X'
	localparam logic [CHAR_W-1:0] CHAR_LO_A    = 8'h61; // 'a'
	localparam logic [CHAR_W-1:0] CHAR_LO_F    = 8'h66; // 'f'
	localparam logic [CHAR_W-1:0] CHAR_LO_X    = 8'h78; // 'x'

	// Letters A-F / a-f carry 1..6 in the low nibble.
	localparam logic [3:0] HEX_LETTER_OFS = 4'd9;
	// Last decimal digit allowed when the value sits exactly at limit/10.
	localparam logic [3:0] DEC_LAST_MAX   = 4'd5;

	localparam logic [VALUE_W-1:0] DEC_MAX_32 = 64'd429496729;
	localparam logic [VALUE_W-1:0] DEC_MAX_64 = 64'd1844674407370955161;
	localparam logic [VALUE_W-1:0] HEX_MAX_32 = 64'h0000_0000_0FFF_FFFF;
	localparam logic [VALUE_W-1:0] HEX_MAX_64 = 64'h0FFF_FFFF_FFFF_FFFF;

	localparam logic [1:0] POS_SAT = 2'd2;

	typedef struct packed {
		logic       term;    // zero byte
		logic       is_x;    // 'x' or 'X'
		logic       dec_ok;  // '0'..'9'
		logic       hex_ok;  // '0'..'9', 'A'..'F', 'a'..'f'
		logic [3:0] digit;
	} char_class_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               ok;
	} result_t;

endpackage

`default_nettype wire

[rtl/anp_char_decode.sv]
// ----------------------------------------------------------------------------
// anp_char_decode
// Classifies one ASCII byte and extracts its digit value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module anp_char_decode (
	input  wire logic [anp_pkg::CHAR_W-1:0] char_code,
	output anp_pkg::char_class_t            cls
);

	logic is_dec;
	logic is_up;
	logic is_lo;

	assign is_dec = (char_code >= anp_pkg::CHAR_ZERO) && (char_code <= anp_pkg::CHAR_NINE);
	assign is_up  = (char_code >= anp_pkg::CHAR_UP_A) && (char_code <= anp_pkg::CHAR_UP_F);
	assign is_lo  = (char_code >= anp_pkg::CHAR_LO_A) && (char_code <= anp_pkg::CHAR_LO_F);

	always_comb begin
		cls.term   = (char_code == anp_pkg::CHAR_NUL);
		cls.is_x   = (char_code == anp_pkg::CHAR_LO_X) || (char_code == anp_pkg::CHAR_UP_X);
		cls.dec_ok = is_dec;
		cls.hex_ok = is_dec || is_up || is_lo;
		cls.digit  = is_dec ? char_code[3:0] : char_code[3:0] + anp_pkg::HEX_LETTER_OFS;
	end

endmodule

`default_nettype wire

[rtl/anp_core.sv]
// ----------------------------------------------------------------------------
// anp_core
// Parser state and its per-byte update; forms the result on the zero byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module anp_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic                 wide_mode,
	input  wire anp_pkg::char_class_t cls,
	output anp_pkg::result_t          res
);

	logic [anp_pkg::VALUE_W-1:0] acc_q;
	logic [1:0]                  pos_q;
	logic                        hex_q;
	logic                        fail_q;

	logic [anp_pkg::VALUE_W-1:0] acc_d;
	logic [1:0]                  pos_d;
	logic                        hex_d;
	logic                        fail_d;

	logic [anp_pkg::VALUE_W-1:0] dec_max;
	logic [anp_pkg::VALUE_W-1:0] hex_max;
	logic [anp_pkg::VALUE_W-1:0] digit_ext;
	logic [anp_pkg::VALUE_W-1:0] acc_x10;
	logic [1:0]                  pos_inc;
	logic                        dec_take;
	logic                        hex_take;
	logic                        bare_prefix;

	assign dec_max   = wide_mode ? anp_pkg::DEC_MAX_64 : anp_pkg::DEC_MAX_32;
	assign hex_max   = wide_mode ? anp_pkg::HEX_MAX_64 : anp_pkg::HEX_MAX_32;
	assign digit_ext = {{(anp_pkg::VALUE_W-4){1'b0}}, cls.digit};
	// x10 as x8 + x2
	assign acc_x10   = {acc_q[anp_pkg::VALUE_W-4:0], 3'b000}
	                 + {acc_q[anp_pkg::VALUE_W-2:0], 1'b0} + digit_ext;
	assign pos_inc   = (pos_q == anp_pkg::POS_SAT) ? pos_q : pos_q + 2'd1;

	assign dec_take = cls.dec_ok && ((acc_q < dec_max) ||
	                  ((acc_q == dec_max) && (cls.digit <= anp_pkg::DEC_LAST_MAX)));
	assign hex_take = cls.hex_ok && (acc_q <= hex_max);

	assign bare_prefix = hex_q && (pos_q == 2'd0);

	always_comb begin
		res.value = bare_prefix ? '0 : acc_q;
		res.ok    = !fail_q && !bare_prefix;
	end

	always_comb begin
		acc_d  = acc_q;
		pos_d  = pos_q;
		hex_d  = hex_q;
		fail_d = fail_q;
		if (cls.term) begin
			acc_d  = '0;
			pos_d  = '0;
			hex_d  = 1'b0;
			fail_d = 1'b0;
		end else if (!fail_q) begin
			if (!hex_q) begin
				if ((pos_q == 2'd1) && (acc_q == '0) && cls.is_x) begin
					hex_d = 1'b1;
					pos_d = '0;
				end else begin
					pos_d = pos_inc;
					if (dec_take) begin
						acc_d = acc_x10;
					end else begin
						fail_d = 1'b1;
					end
				end
			end else begin
				pos_d = pos_inc;
				if (hex_take) begin
					acc_d = {acc_q[anp_pkg::VALUE_W-5:0], cls.digit};
				end else begin
					fail_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pos_q  <= '0;
			hex_q  <= 1'b0;
			fail_q <= 1'b0;
		end else if (step) begin
			acc_q  <= acc_d;
			pos_q  <= pos_d;
			hex_q  <= hex_d;
			fail_q <= fail_d;
		end
	end

endmodule

`default_nettype wire

[rtl/ascii_number_parser.sv]
// ----------------------------------------------------------------------------
// ascii_number_parser
// Parses a zero-terminated ASCII string of decimal or 0x-prefixed hex digits.
// ----------------------------------------------------------------------------
// One byte is taken per cycle on s_axis; a new byte can enter every cycle.
// Each byte passes an input register, then the decode and accumulate logic
// (a x10 shift-add or a 4-bit shift) updates the parser state. A result is
// captured in the output register as its zero byte leaves the input register
// and is held on m_axis until taken. Input backpressure occurs only while a
// finished result waits in the output register and the next terminating byte
// wants to replace it. wide_mode (cfg_data) selects a 32-bit or 64-bit
// overflow limit; write it only while no byte is in flight. A change in the
// middle of a string applies from the next digit on.
`timescale 1ns / 1ps
`default_nettype none

module ascii_number_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,        // [0] wide_mode
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,    // [7:0] char_code
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,    // [63:0] value
	output logic             m_axis_tuser     // [0] ok
);

	logic                         wide_q;
	logic                         valid_s1;
	logic [anp_pkg::CHAR_W-1:0]   char_s1;
	logic                         out_valid_q;
	anp_pkg::result_t             out_q;

	anp_pkg::char_class_t         cls;
	anp_pkg::result_t             res;
	logic                         advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			wide_q <= cfg_data;
		end
	end

	anp_char_decode u_decode (
		.char_code (char_s1),
		.cls       (cls)
	);

	// Hold a terminating byte while the previous result is still unclaimed.
	assign advance       = valid_s1 && (!cls.term || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	anp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.wide_mode (wide_q),
		.cls       (cls),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && cls.term) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cls.term) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.value;
	assign m_axis_tuser  = out_q.ok;

endmodule

`default_nettype wire

[rtl/anp_checker.sv]
// ----------------------------------------------------------------------------
// anp_checker
// Port-level checks for the ASCII number parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ascii_number_parser_macros.svh"

module anp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_ready,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [7:0]  s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [63:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);

	// A fresh result comes from a zero byte taken earlier on s_axis.
	`ANP_ASSERT_IMP(a_result_from_nul, clk, arst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready && (s_axis_tdata == anp_pkg::CHAR_NUL), 2))

	// With the output register empty, input is never stalled.
	`ANP_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready)

	// Config port never stalls.
	`ANP_ASSERT_IMP(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready)

	// Stalled result holds.
	`ANP_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind ascii_number_parser anp_checker u_anp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_ready     (cfg_ready),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[tb/tb_ascii_number_parser.sv]
// ----------------------------------------------------------------------------
// tb_ascii_number_parser
// Self-checking bench for the ASCII decimal/hex number parser. Strings are fed
// byte by byte with random gaps and output stalls. A scoreboard predicts each
// result from the accepted bytes and checks the value and ok flag in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ascii_number_parser;
	import anp_pkg::*;

	localparam int unsigned IDLE_LIMIT  = 3000;
	localparam int unsigned DRAIN_WAIT  = 8;
	localparam int unsigned BYTES_PHASE = 85;
	localparam int unsigned NUM_PHASES  = 8;
	localparam logic [VALUE_W-1:0] DEC_BASE  = 64'd10;
	localparam logic [VALUE_W-1:0] LIMIT_32  = 64'h0000_0000_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] LIMIT_64  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [CHAR_W-1:0]  CHAR_HIGH = 8'hFF;
	localparam logic [CHAR_W-1:0]  CHAR_B80  = 8'h80;
	localparam logic [CHAR_W-1:0]  CASE_BIT  = 8'h20;

	class parse_scoreboard;
		logic               wide;
		logic [VALUE_W-1:0] acc;
		logic [1:0]         pos;
		logic               hex_mode;
		logic               failed;
		result_t            want_q[$];
		int                 errors;

		function new();
			wide   = 1'b0;
			errors = 0;
			clear_string();
		endfunction

		function void clear_string();
			acc      = '0;
			pos      = '0;
			hex_mode = 1'b0;
			failed   = 1'b0;
		endfunction

		function void set_wide(logic w);
			wide = w;
		endfunction

		function int pending();
			return want_q.size();
		endfunction

		// Advance the parser state by one accepted byte.
		function void note_char(logic [CHAR_W-1:0] c);
			logic [VALUE_W-1:0] lim;
			logic [VALUE_W-1:0] dec_cap;
			logic [VALUE_W-1:0] d;
			logic               is_digit;
			result_t            r;
			lim = wide ? LIMIT_64 : LIMIT_32;
			if (c == CHAR_NUL) begin
				r.value = acc;
				r.ok    = !failed;
				if (hex_mode && pos == 2'd0) begin
					r.value = '0;
					r.ok    = 1'b0;
				end
				want_q.push_back(r);
				clear_string();
				return;
			end
			if (failed)
				return;
			if (!hex_mode) begin
				if (pos == 2'd1 && acc == '0 && (c == CHAR_LO_X || c == CHAR_UP_X)) begin
					hex_mode = 1'b1;
					pos      = 2'd0;
					return;
				end
				if (pos < POS_SAT)
					pos = pos + 2'd1;
				if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
					d       = 64'(c - CHAR_ZERO);
					dec_cap = lim / DEC_BASE;
					if (acc < dec_cap || (acc == dec_cap && d <= 64'(DEC_LAST_MAX)))
						acc = acc * DEC_BASE + d;
					else
						failed = 1'b1;
				end else begin
					failed = 1'b1;
				end
				return;
			end
			if (pos < POS_SAT)
				pos = pos + 2'd1;
			is_digit = 1'b1;
			if (c >= CHAR_ZERO && c <= CHAR_NINE)
				d = 64'(c - CHAR_ZERO);
			else if (c >= CHAR_UP_A && c <= CHAR_UP_F)
				d = 64'(c - CHAR_UP_A) + DEC_BASE;
			else if (c >= CHAR_LO_A && c <= CHAR_LO_F)
				d = 64'(c - CHAR_LO_A) + DEC_BASE;
			else begin
				d        = '0;
				is_digit = 1'b0;
			end
			if (is_digit && acc <= (lim >> 4))
				acc = (acc << 4) + d;
			else
				failed = 1'b1;
		endfunction

		function void check_result(logic [VALUE_W-1:0] value, logic ok);
			result_t w;
			if (want_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result value %h ok %b", $time, value, ok);
				return;
			end
			w = want_q.pop_front();
			if (value !== w.value) begin
				errors++;
				$display("%0t: value mismatch, expected %h, actual %h", $time, w.value, value);
			end
			if (ok !== w.ok) begin
				errors++;
				$display("%0t: ok mismatch, expected %b, actual %b", $time, w.ok, ok);
			end
		endfunction
	endclass

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               cfg_valid     = 1'b0;
	logic               cfg_ready;
	logic               cfg_data      = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [CHAR_W-1:0]  s_axis_tdata  = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [VALUE_W-1:0] m_axis_tdata;
	logic               m_axis_tuser;

	parse_scoreboard    sb = new();
	logic [CHAR_W-1:0]  char_q[$];
	logic               calm = 1'b0;
	int unsigned        sink_hold = 0;
	int unsigned        idle_cycles = 0;

	ascii_number_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one; none while calm.
	function automatic int unsigned gap_len();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	always @(posedge clk) begin
		int unsigned n;
		if (sink_hold > 0) begin
			sink_hold = sink_hold - 1;
		end else begin
			n = gap_len();
			if (n == 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				sink_hold = n - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_char(logic [CHAR_W-1:0] c);
		int unsigned gap;
		gap = gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_char(c);
	endtask

	task automatic drive_chars();
		while (char_q.size() > 0)
			send_char(char_q.pop_front());
	endtask

	// Drop valid, then hold until every result is out and the pipe has drained.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_mode(logic w);
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		do @(posedge clk); while (!cfg_ready);
		sb.set_wide(w);
		cfg_valid <= 1'b0;
	endtask

	function automatic void push_text(string s, bit mix_case);
		logic [CHAR_W-1:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s.getc(i);
			if (mix_case && ((c >= CHAR_LO_A && c <= CHAR_LO_F) || c == CHAR_LO_X) &&
					$urandom_range(1))
				c = c & ~CASE_BIT;
			char_q.push_back(c);
		end
	endfunction

	function automatic logic [VALUE_W-1:0] rand_value();
		return {$urandom, $urandom} >> $urandom_range(63);
	endfunction

	// Queue one zero-terminated string of a random kind.
	function automatic void queue_string();
		logic [VALUE_W-1:0] lim;
		logic [VALUE_W-1:0] v;
		int unsigned        kind;
		int unsigned        n;
		string              s;
		lim  = sb.wide ? LIMIT_64 : LIMIT_32;
		kind = $urandom_range(99);
		if (kind < 20) begin
			// plain decimal, sometimes with leading zeros or far too long
			if ($urandom_range(3) == 0) begin
				n = $urandom_range(22, 1);
				for (int i = 0; i < n; i++)
					char_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
			end else begin
				repeat ($urandom_range(2)) char_q.push_back(CHAR_ZERO);
				push_text($sformatf("%0d", rand_value()), 1'b0);
			end
		end else if (kind < 35) begin
			// decimal at the limit edge
			v = lim - 64'($urandom_range(3));
			if (!sb.wide && $urandom_range(1))
				v = lim + 64'($urandom_range(3));
			s = $sformatf("%0d", v);
			case ($urandom_range(2))
				0: s.putc(s.len() - 1, CHAR_ZERO + 8'($urandom_range(9)));
				1: s = {s, string'(CHAR_ZERO + 8'($urandom_range(9)))};
				default: ;
			endcase
			push_text(s, 1'b0);
		end else if (kind < 55) begin
			// plain hex, sometimes padded
			s = "0x";
			repeat ($urandom_range(2)) s = {s, "0"};
			push_text({s, $sformatf("%0h", rand_value())}, 1'b1);
		end else if (kind < 70) begin
			// hex at the limit edge
			v = lim - 64'($urandom_range(3));
			if (!sb.wide && $urandom_range(1))
				v = lim + 64'($urandom_range(3));
			s = {"0x", $sformatf("%0h", v)};
			if ($urandom_range(2) == 0)
				s = {s, $sformatf("%0h", 4'($urandom_range(15)))};
			push_text(s, 1'b1);
		end else if (kind < 78) begin
			// noise over the nonzero byte range
			n = $urandom_range(6, 1);
			for (int i = 0; i < n; i++)
				char_q.push_back(8'($urandom_range(255, 1)));
		end else if (kind < 90) begin
			// digits with one random nonzero byte inserted among them
			n = $urandom_range(8, 1);
			if ($urandom_range(1))
				push_text("0x", 1'b1);
			for (int i = 0; i < n; i++)
				char_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
			char_q.insert($urandom_range(char_q.size()), 8'($urandom_range(255, 1)));
		end else begin
			case ($urandom_range(5))
				0: ;
				1: push_text("0x", 1'b1);
				2: push_text("00x12", 1'b1);
				3: push_text("1x5", 1'b1);
				4: push_text("0xx", 1'b1);
				default: push_text("x1", 1'b1);
			endcase
		end
		char_q.push_back(CHAR_NUL);
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: narrow mode from reset
		calm = 1'b1;
		char_q.push_back(CHAR_NUL);
		push_text("0x", 1'b0);
		char_q.push_back(CHAR_NUL);
		push_text("0XfA9", 1'b0);
		char_q.push_back(CHAR_NUL);
		push_text("7", 1'b0);
		char_q.push_back(CHAR_HIGH);
		push_text("5", 1'b0);
		char_q.push_back(CHAR_NUL);
		char_q.push_back(CHAR_B80);
		char_q.push_back(CHAR_NUL);
		drive_chars();

		// widen in the middle of a hex string
		calm = 1'b0;
		push_text("0x1234567", 1'b0);
		drive_chars();
		wait_idle();
		write_mode(1'b1);
		push_text("89AB", 1'b0);
		char_q.push_back(CHAR_NUL);
		// narrow with a value already past the 32-bit limit, then end it
		push_text("99999999999", 1'b0);
		drive_chars();
		wait_idle();
		write_mode(1'b0);
		char_q.push_back(CHAR_NUL);
		drive_chars();
		wait_idle();
		// widen, enter 4294967296, then narrow so one more digit must fail
		write_mode(1'b1);
		push_text("4294967296", 1'b0);
		drive_chars();
		wait_idle();
		write_mode(1'b0);
		push_text("1", 1'b0);
		char_q.push_back(CHAR_NUL);
		drive_chars();
		wait_idle();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_mode(ph < 2 ? 1'(ph) : 1'($urandom_range(1)));
			calm = (ph % 3 == 0);
			for (int sent = 0; sent < BYTES_PHASE; ) begin
				queue_string();
				sent += char_q.size();
				drive_chars();
			end
			wait_idle();
		end

		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/anp_pkg.sv
rtl/anp_char_decode.sv
rtl/anp_core.sv
rtl/ascii_number_parser.sv
rtl/anp_checker.sv
tb/tb_ascii_number_parser.sv
